FILE: sv/unordered_list_table_core_assert.svh
// Assertion macros shared by the list table RTL.
// Needs clk and rst in scope where a macro is used.
`ifndef UNORDERED_LIST_TABLE_CORE_ASSERT_SVH
`define UNORDERED_LIST_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define ULT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ULT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ult_pkg.sv
// Types and codes for the unordered list table.
// No dependencies; used by ult_ctrl, ult_dp and the top level.
package ult_pkg;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_SEARCH  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;
  localparam logic [2:0] OP_NEXT    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] data_out;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       up_init;
    logic       scan;
    logic       dn_init;
    logic       shift_up;
    logic       shift_dn;
    logic       ins_fin;
    logic       dec;
    logic       clr;
    logic       iter_rst;
    logic       next_rd;
    logic       set_res;
    logic       res_found;
    logic       res_take_data;
    logic [1:0] res_status;
    logic       finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic miss_last;
    logic up_done;
    logic dn_done;
    logic op_del;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/ult_ctrl.sv
// Sequencer for the list table: decodes the opcode and steps the datapath.
// Depends on ult_pkg.
module ult_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2:0]      opcode,
  output logic            in_ready,
  input  ult_pkg::sts_t   sts,
  output ult_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (opcode)
            ult_pkg::OP_INSERT: begin
              cmd.iter_rst = 1'b1;
              if (sts.full) begin
                cmd.set_res    = 1'b1;
                cmd.res_status = ult_pkg::ST_FULL;
                state_next     = S_DONE;
              end else begin
                cmd.up_init = 1'b1;
                state_next  = S_SHUP;
              end
            end
            ult_pkg::OP_SEARCH, ult_pkg::OP_DELETE: begin
              cmd.iter_rst = (opcode == ult_pkg::OP_DELETE);
              if (sts.empty) begin
                cmd.set_res    = 1'b1;
                cmd.res_status = ult_pkg::ST_NOMATCH;
                state_next     = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            ult_pkg::OP_CLEAR: begin
              cmd.clr      = 1'b1;
              cmd.iter_rst = 1'b1;
              cmd.set_res  = 1'b1;
              state_next   = S_DONE;
            end
            ult_pkg::OP_RESTART: begin
              cmd.iter_rst = 1'b1;
              cmd.set_res  = 1'b1;
              state_next   = S_DONE;
            end
            ult_pkg::OP_NEXT: begin
              if (sts.empty) begin
                cmd.iter_rst   = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ult_pkg::ST_EMPTY;
                state_next     = S_DONE;
              end else begin
                cmd.next_rd = 1'b1;
                state_next  = S_RD;
              end
            end
            default: begin
              cmd.set_res = 1'b1;
              state_next  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (sts.op_del) begin
            cmd.dn_init = 1'b1;
            state_next  = S_SHDN;
          end else begin
            cmd.set_res   = 1'b1;
            cmd.res_found = 1'b1;
            state_next    = S_DONE;
          end
        end else if (sts.miss_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ult_pkg::ST_NOMATCH;
          state_next     = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHUP: begin
        if (sts.up_done) begin
          cmd.ins_fin = 1'b1;
          cmd.set_res = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.shift_up = 1'b1;
        end
      end
      S_SHDN: begin
        if (sts.dn_done) begin
          cmd.dec       = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_found = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.shift_dn = 1'b1;
        end
      end
      S_RD: begin
        cmd.set_res       = 1'b1;
        cmd.res_take_data = 1'b1;
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/ult_dp.sv
// Datapath for the list table: entry memory, count, scan pointer,
// iterator and the output register. Depends on ult_pkg.
module ult_dp #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ult_pkg::in_item_t   in_item,
  input  ult_pkg::cmd_t       cmd,
  output ult_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ult_pkg::out_item_t  out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic [SW-1:0] mem [CAPACITY];

  logic [CW-1:0] count;
  logic [AW-1:0] iter_pos;
  logic          iter_act;
  logic [2:0]    op_r;
  logic [SW-1:0] val_r;
  logic [CW-1:0] ptr;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic [SW-1:0] rdata;
  logic          res_found;
  logic [1:0]    res_status;
  logic [SW-1:0] res_data;

  logic          ptr_lt_cnt;
  logic [CW-1:0] ptr_m1;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] next_pos;
  logic [CW-1:0] next_pos_p1;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  assign ptr_lt_cnt  = (ptr < count);
  assign ptr_m1      = ptr - CW'(1);
  assign cnt_m1      = count - CW'(1);
  // iterator wraps to the newest entry when idle or past the end
  assign next_pos    = (!iter_act || (CW'(iter_pos) >= count)) ? '0 : iter_pos;
  assign next_pos_p1 = CW'(next_pos) + CW'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    if ((cmd.scan || cmd.shift_dn) && ptr_lt_cnt) begin
      rd_en = 1'b1;
    end
    if (cmd.shift_up && (ptr != '0)) begin
      rd_en   = 1'b1;
      rd_addr = ptr_m1[AW-1:0];
    end
    if (cmd.next_rd) begin
      rd_en   = 1'b1;
      rd_addr = next_pos;
    end
  end

  // a move writes the entry read on the previous cycle one slot over
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx + AW'(1);
    wr_data = rdata;
    if (cmd.shift_up && rd_vld) begin
      wr_en = 1'b1;
    end
    if (cmd.shift_dn && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - AW'(1);
    end
    if (cmd.ins_fin) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    sts.full      = (count == CW'(CAPACITY));
    sts.empty     = (count == '0);
    sts.hit       = rd_vld && (rdata == val_r);
    sts.miss_last = rd_vld && (rdata != val_r) && (CW'(rd_idx) == cnt_m1);
    sts.up_done   = (ptr == '0) && !rd_vld;
    sts.dn_done   = !ptr_lt_cnt && !rd_vld;
    sts.op_del    = (op_r == ult_pkg::OP_DELETE);
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      iter_pos  <= '0;
      iter_act  <= 1'b0;
      op_r      <= ult_pkg::OP_INSERT;
      ptr       <= '0;
      rd_idx    <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r   <= in_item.opcode;
        // an insert walks down from the oldest entry, a scan up from the newest
        ptr    <= cmd.up_init ? count : '0;
        rd_vld <= 1'b0;
      end
      if (cmd.scan || cmd.shift_dn) begin
        rd_vld <= ptr_lt_cnt;
        if (ptr_lt_cnt) begin
          rd_idx <= ptr[AW-1:0];
          ptr    <= ptr + CW'(1);
        end
      end
      if (cmd.shift_up) begin
        rd_vld <= (ptr != '0);
        if (ptr != '0) begin
          rd_idx <= ptr_m1[AW-1:0];
          ptr    <= ptr_m1;
        end
      end
      if (cmd.dn_init) begin
        ptr    <= CW'(rd_idx) + CW'(1);
        rd_vld <= 1'b0;
      end
      if (cmd.ins_fin) begin
        count <= count + CW'(1);
      end
      if (cmd.dec) begin
        count <= cnt_m1;
      end
      if (cmd.clr) begin
        count <= '0;
      end
      if (cmd.iter_rst) begin
        iter_pos <= '0;
        iter_act <= 1'b0;
      end
      if (cmd.next_rd) begin
        if (next_pos_p1 >= count) begin
          iter_pos <= '0;
          iter_act <= 1'b0;
        end else begin
          iter_pos <= next_pos_p1[AW-1:0];
          iter_act <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_item.data_value[SW-1:0];
    end
    if (cmd.set_res) begin
      res_found  <= cmd.res_found;
      res_status <= cmd.res_status;
      res_data   <= cmd.res_take_data ? rdata : '0;
    end
    if (cmd.finish) begin
      out_item.found       <= res_found;
      out_item.data_out    <= 32'(res_data);
      out_item.entry_count <= 5'(count);
      out_item.status      <= res_status;
    end
  end

endmodule

FILE: sv/unordered_list_table_core.sv
// Bounded unordered list of words, newest first, driven by one opcode per item
// (insert, search, delete, clear, restart iterator, get next); each item yields
// one result carrying the entry count after the operation. Clear, restart, a full
// insert, and search, delete or get next on an empty list, leave the entry memory
// untouched; get next reads one entry, and insert, search and delete walk the stored
// entries one per cycle through the entry memory, which has one read and one write
// port. A new item is taken while the previous result still waits in the output
// register; a finished item stalls only until that register frees.
// Depends on ult_pkg, ult_ctrl, ult_dp and unordered_list_table_core_assert.svh.
`include "unordered_list_table_core_assert.svh"

module unordered_list_table_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ult_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ult_pkg::out_item_t  out_item
);

  ult_pkg::cmd_t cmd;
  ult_pkg::sts_t sts;

  ult_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_item.opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ult_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `ULT_ASSERT_NOW(a_no_insert_when_full, cmd.ins_fin, !sts.full, "insert into full list")
  `ULT_ASSERT_NOW(a_finish_needs_slot, cmd.finish, sts.out_free, "result overwrote pending item")
  `ULT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")

endmodule

FILE: verif/tb_unordered_list_table_core.sv
// Self-checking testbench for unordered_list_table_core: a queue-fed driver and a clocked
// monitor compare every result against an in-bench list and iterator predictor.
// Depends on ult_pkg and the unordered_list_table_core RTL.
module tb_unordered_list_table_core;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  ult_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  ult_pkg::out_item_t out_item;

  // stimulus and expectations
  ult_pkg::in_item_t  stim_items[$];
  ult_pkg::out_item_t expected_results[$];
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        cycles = 0;
  logic [31:0] value_pool[6];

  // predicted list state
  logic [31:0] list_words[CAPACITY];
  int          list_count = 0;
  int          walk_pos = 0;
  logic        walk_active = 1'b0;

  unordered_list_table_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void walk_restart();
    walk_pos = 0;
    walk_active = 1'b0;
  endfunction

  // index of the newest matching word, list_count when absent
  function automatic int newest_match(logic [31:0] word);
    for (int i = 0; i < list_count; i++)
      if (list_words[i] == word) return i;
    return list_count;
  endfunction

  function automatic ult_pkg::out_item_t list_apply(ult_pkg::in_item_t item);
    ult_pkg::out_item_t r;
    int                 idx;
    r = '0;
    r.status = ult_pkg::ST_OK;
    case (item.opcode)
      ult_pkg::OP_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = ult_pkg::ST_FULL;
        end else begin
          for (int i = list_count; i > 0; i--) list_words[i] = list_words[i-1];
          list_words[0] = item.data_value;
          list_count++;
        end
        walk_restart();
      end
      ult_pkg::OP_SEARCH: begin
        if (newest_match(item.data_value) < list_count) r.found = 1'b1;
        else r.status = ult_pkg::ST_NOMATCH;
      end
      ult_pkg::OP_DELETE: begin
        idx = newest_match(item.data_value);
        if (idx < list_count) begin
          r.found = 1'b1;
          for (int i = idx; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end else begin
          r.status = ult_pkg::ST_NOMATCH;
        end
        walk_restart();
      end
      ult_pkg::OP_CLEAR: begin
        list_count = 0;
        walk_restart();
      end
      ult_pkg::OP_RESTART: walk_restart();
      ult_pkg::OP_NEXT: begin
        if (list_count == 0) begin
          r.status = ult_pkg::ST_EMPTY;
          walk_restart();
        end else begin
          if (!walk_active || walk_pos >= list_count) walk_pos = 0;
          r.data_out = list_words[walk_pos];
          walk_pos++;
          // past the oldest entry the walk wraps to the newest
          if (walk_pos >= list_count) walk_restart();
          else walk_active = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = list_count[4:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  task automatic push_item(logic [2:0] op, logic [31:0] word);
    ult_pkg::in_item_t item;
    item.opcode = op;
    item.data_value = word;
    stim_items.push_back(item);
  endtask

  // mostly well-formed traffic around a small value pool, so hits and
  // deletes of duplicates are common; bursts reach the full list and wrap walks
  task automatic queue_random(int n);
    int added;
    int roll;
    int len;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        len = CAPACITY + $urandom_range(1, 3);
        repeat (len) push_item(ult_pkg::OP_INSERT, pick_value());
        added += len;
      end else if (roll < 11) begin
        len = $urandom_range(CAPACITY, 2 * CAPACITY + 2);
        repeat (len) push_item(ult_pkg::OP_NEXT, $urandom);
        added += len;
      end else begin
        roll = $urandom_range(99);
        if (roll < 32) push_item(ult_pkg::OP_INSERT, pick_value());
        else if (roll < 48) push_item(ult_pkg::OP_SEARCH, pick_value());
        else if (roll < 64) push_item(ult_pkg::OP_DELETE, pick_value());
        else if (roll < 86) push_item(ult_pkg::OP_NEXT, $urandom);
        else if (roll < 92) push_item(ult_pkg::OP_RESTART, $urandom);
        else if (roll < 96) push_item(ult_pkg::OP_CLEAR, $urandom);
        else push_item(roll[0] ? OP_SPARE_7 : OP_SPARE_6, $urandom);
        added++;
      end
    end
  endtask

  // driver: a new item is presented only after the current one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= stim_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    ult_pkg::out_item_t exp_r;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) expected_results.push_back(list_apply(in_item));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, out_item);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("found", 32'(exp_r.found), 32'(out_item.found));
          check_field("data_out", exp_r.data_out, out_item.data_out);
          check_field("entry_count", 32'(exp_r.entry_count), 32'(out_item.entry_count));
          check_field("status", 32'(exp_r.status), 32'(out_item.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("tb_unordered_list_table_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) value_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list cases, extremes, duplicates, wrap, spare opcodes
    push_item(ult_pkg::OP_NEXT, 32'h0);
    push_item(ult_pkg::OP_SEARCH, 32'h0);
    push_item(ult_pkg::OP_DELETE, 32'hFFFF_FFFF);
    push_item(ult_pkg::OP_INSERT, 32'h0000_0000);
    push_item(ult_pkg::OP_INSERT, 32'hFFFF_FFFF);
    push_item(ult_pkg::OP_INSERT, 32'hA5A5_5A5A);
    push_item(ult_pkg::OP_INSERT, 32'hFFFF_FFFF);
    push_item(ult_pkg::OP_SEARCH, 32'hA5A5_5A5A);
    push_item(ult_pkg::OP_SEARCH, 32'h5A5A_A5A5);
    repeat (5) push_item(ult_pkg::OP_NEXT, 32'hFFFF_FFFF);
    push_item(ult_pkg::OP_RESTART, 32'h0);
    push_item(ult_pkg::OP_NEXT, 32'h0);
    push_item(ult_pkg::OP_DELETE, 32'hFFFF_FFFF);
    push_item(ult_pkg::OP_NEXT, 32'h0);
    push_item(ult_pkg::OP_DELETE, 32'h1234_5678);
    push_item(OP_SPARE_6, 32'hFFFF_FFFF);
    push_item(OP_SPARE_7, 32'h0);
    push_item(ult_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    push_item(ult_pkg::OP_NEXT, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      queue_random(95);
      while (stim_items.size() != 0 || in_valid || expected_results.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_unordered_list_table_core: PASS");
    else
      $display("tb_unordered_list_table_core: FAIL");
    $finish;
  end

endmodule
